@@ rtl/core/vertex_triple_index_dedup_assert.svh @@
// Assertion macros for the vertex triple index dedup checker
`ifndef VERTEX_TRIPLE_INDEX_DEDUP_ASSERT_SVH
`define VERTEX_TRIPLE_INDEX_DEDUP_ASSERT_SVH

// Same-cycle implication, disabled while reset is high
`define VTID_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high
`define VTID_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/core/vtid_pkg.sv @@
// Shared constants for the vertex triple index dedup block
`default_nettype none

package vtid_pkg;

   // Width of each source index field on the request channel
   localparam int REQ_INDEX_WIDTH = 16;

   // Width of the unified index field on the response channel
   localparam int UNIFIED_WIDTH = 10;

   // Hash mixing word and its constants
   localparam int MIX_WIDTH = 32;
   localparam int ROT_NORMAL = 11;
   localparam int ROT_TEXCOORD = 21;
   localparam logic [MIX_WIDTH-1:0] HASH_MULT = 32'h9E37_79B1;

endpackage

`default_nettype wire

@@ rtl/core/vtid_if.sv @@
// Request and response channel interfaces for the vertex triple index dedup block
`default_nettype none

interface vtid_req_if;
   logic valid;
   logic ready;
   logic [vtid_pkg::REQ_INDEX_WIDTH-1:0] position_index;
   logic [vtid_pkg::REQ_INDEX_WIDTH-1:0] normal_index;
   logic [vtid_pkg::REQ_INDEX_WIDTH-1:0] texcoord_index;
   logic restart;

   modport source (
      output valid, position_index, normal_index, texcoord_index, restart,
      input  ready
   );

   modport sink (
      input  valid, position_index, normal_index, texcoord_index, restart,
      output ready
   );
endinterface

interface vtid_rsp_if;
   logic valid;
   logic ready;
   logic [vtid_pkg::UNIFIED_WIDTH-1:0] unified_index;
   logic is_new;
   logic table_full;

   modport source (
      output valid, unified_index, is_new, table_full,
      input  ready
   );

   modport sink (
      input  valid, unified_index, is_new, table_full,
      output ready
   );
endinterface

`default_nettype wire

@@ rtl/core/vertex_triple_index_dedup.sv @@
// Top level of the vertex triple index dedup block
//
// Usage: each request transaction carries one face corner (position, normal
// and texture-coordinate index, plus a restart flag); each one returns
// exactly one response transaction with the unified index, is_new and
// table_full, in request order. Both channels are valid/ready.
// Triples live in a hash table in one RAM with a registered read; a bucket
// held by another triple sends the probe on to the next bucket. A corner
// steps through a probe and a check state per bucket, then a response
// state that moves its result into the response register. One corner is in
// flight at a time: no corner is taken until the current one is through
// its lookup. The next is accepted once the current result sits in the
// response register, so a stalled receiver holds one result while the
// next corner is being looked up. A further stall holds the block in its
// response step until the register is taken.
// Reset and restart: a clearing pass writes every bucket empty, one bucket
// per cycle, during which no request is taken. A restart corner runs the
// pass first, then is stored as index 0.
`default_nettype none

module vertex_triple_index_dedup #(
   parameter int TABLE_DEPTH        = 1024,
   parameter int SOURCE_INDEX_WIDTH = 16
) (
   input wire logic   clock,
   input wire logic   reset,
   vtid_req_if.sink   req_chan,
   vtid_rsp_if.source rsp_chan
);

   localparam int RIW        = vtid_pkg::REQ_INDEX_WIDTH;
   localparam int UIDX_W     = vtid_pkg::UNIFIED_WIDTH;
   localparam int KEY_W      = (SOURCE_INDEX_WIDTH < RIW) ? SOURCE_INDEX_WIDTH : RIW;
   localparam int KEY3_W     = 3 * KEY_W;
   localparam int IDX_W      = $clog2(TABLE_DEPTH);
   localparam int HASH_DEPTH = 1 << IDX_W;
   localparam int CNT_W      = $clog2(TABLE_DEPTH + 1);
   localparam int ENTRY_W    = 1 + KEY3_W + IDX_W;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_PROBE,
      ST_CHECK,
      ST_RESP
   } state_type;

   state_type           state_ff,     state_in;
   logic                pend_ff,      pend_in;
   logic [IDX_W-1:0]    clr_addr_ff,  clr_addr_in;
   logic [IDX_W-1:0]    bucket_ff,    bucket_in;
   logic [IDX_W-1:0]    probe_ff,     probe_in;
   logic [CNT_W-1:0]    count_ff,     count_in;
   logic [KEY3_W-1:0]   key_ff,       key_in;
   logic [UIDX_W-1:0]   res_index_ff, res_index_in;
   logic                res_new_ff,   res_new_in;
   logic                res_full_ff,  res_full_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [UIDX_W-1:0]   rsp_index_ff, rsp_index_in;
   logic                rsp_new_ff,   rsp_new_in;
   logic                rsp_full_ff,  rsp_full_in;

   logic                req_accept;
   logic [KEY_W-1:0]    pos_key;
   logic [KEY_W-1:0]    nrm_key;
   logic [KEY_W-1:0]    tex_key;
   logic [IDX_W-1:0]    hash_bucket;

   logic                ram_wr_en;
   logic [IDX_W-1:0]    ram_wr_addr;
   logic [ENTRY_W-1:0]  ram_wr_data;
   logic                ram_rd_en;
   logic [ENTRY_W-1:0]  ram_rd_data;

   logic                rd_valid;
   logic [KEY3_W-1:0]   rd_key;
   logic [IDX_W-1:0]    rd_idx;
   logic                has_room;
   logic                last_probe;
   logic                rsp_free;

   // Reduce incoming indices to the stored key width
   assign pos_key    = req_chan.position_index[KEY_W-1:0];
   assign nrm_key    = req_chan.normal_index[KEY_W-1:0];
   assign tex_key    = req_chan.texcoord_index[KEY_W-1:0];

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_accept     = req_chan.valid && req_chan.ready;

   vtid_hash #(
      .KEY_WIDTH (KEY_W),
      .HASH_BITS (IDX_W)
   ) u_hash (
      .position_key (pos_key),
      .normal_key   (nrm_key),
      .texcoord_key (tex_key),
      .bucket       (hash_bucket)
   );

   vtid_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (HASH_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (bucket_ff),
      .rd_data (ram_rd_data)
   );

   // Split a bucket into occupied flag, key and stored index
   assign rd_valid   = ram_rd_data[ENTRY_W-1];
   assign rd_key     = ram_rd_data[IDX_W +: KEY3_W];
   assign rd_idx     = ram_rd_data[IDX_W-1:0];
   assign has_room   = (count_ff < CNT_W'(TABLE_DEPTH));
   assign last_probe = (probe_ff == {IDX_W{1'b1}});
   assign rsp_free   = !rsp_valid_ff || rsp_chan.ready;
   assign ram_rd_en  = (state_ff == ST_PROBE);

   // Sequence clearing, probing and the response hand-off
   always_comb begin
      state_in     = state_ff;
      pend_in      = pend_ff;
      clr_addr_in  = clr_addr_ff;
      bucket_in    = bucket_ff;
      probe_in     = probe_ff;
      count_in     = count_ff;
      key_in       = key_ff;
      res_index_in = res_index_ff;
      res_new_in   = res_new_ff;
      res_full_in  = res_full_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_index_in = rsp_index_ff;
      rsp_new_in   = rsp_new_ff;
      rsp_full_in  = rsp_full_ff;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = clr_addr_ff;
      ram_wr_data  = '0;

      case (state_ff)
         ST_CLEAR: begin
            ram_wr_en   = 1'b1;
            clr_addr_in = clr_addr_ff + IDX_W'(1);
            if (clr_addr_ff == {IDX_W{1'b1}}) begin
               state_in = pend_ff ? ST_PROBE : ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_accept) begin
               key_in    = {pos_key, nrm_key, tex_key};
               bucket_in = hash_bucket;
               probe_in  = '0;
               pend_in   = 1'b1;
               if (req_chan.restart) begin
                  count_in    = '0;
                  clr_addr_in = '0;
                  state_in    = ST_CLEAR;
               end else begin
                  state_in = ST_PROBE;
               end
            end
         end
         ST_PROBE: begin
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (rd_valid && (rd_key == key_ff)) begin
               // Hit: return the stored index
               res_index_in = UIDX_W'(rd_idx);
               res_new_in   = 1'b0;
               res_full_in  = 1'b0;
               state_in     = ST_RESP;
            end else if (!rd_valid) begin
               // Empty bucket: the triple is absent
               if (has_room) begin
                  ram_wr_en    = 1'b1;
                  ram_wr_addr  = bucket_ff;
                  ram_wr_data  = {1'b1, key_ff, IDX_W'(count_ff)};
                  count_in     = count_ff + CNT_W'(1);
                  res_index_in = UIDX_W'(count_ff);
                  res_new_in   = 1'b1;
                  res_full_in  = 1'b0;
               end else begin
                  res_index_in = '0;
                  res_new_in   = 1'b0;
                  res_full_in  = 1'b1;
               end
               state_in = ST_RESP;
            end else if (last_probe) begin
               // Every bucket occupied by other triples: table is full
               res_index_in = '0;
               res_new_in   = 1'b0;
               res_full_in  = 1'b1;
               state_in     = ST_RESP;
            end else begin
               bucket_in = bucket_ff + IDX_W'(1);
               probe_in  = probe_ff + IDX_W'(1);
               state_in  = ST_PROBE;
            end
         end
         ST_RESP: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_index_in = res_index_ff;
               rsp_new_in   = res_new_ff;
               rsp_full_in  = res_full_ff;
               pend_in      = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Hold state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         pend_ff      <= 1'b0;
         clr_addr_ff  <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pend_ff      <= pend_in;
         clr_addr_ff  <= clr_addr_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      bucket_ff    <= bucket_in;
      probe_ff     <= probe_in;
      key_ff       <= key_in;
      res_index_ff <= res_index_in;
      res_new_ff   <= res_new_in;
      res_full_ff  <= res_full_in;
      rsp_index_ff <= rsp_index_in;
      rsp_new_ff   <= rsp_new_in;
      rsp_full_ff  <= rsp_full_in;
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.unified_index = rsp_index_ff;
   assign rsp_chan.is_new        = rsp_new_ff;
   assign rsp_chan.table_full    = rsp_full_ff;

endmodule

`default_nettype wire

@@ rtl/core/vtid_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data
`default_nettype none

module vtid_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write on request, register read data
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ rtl/core/vtid_hash.sv @@
// Bucket hash over one index triple: rotate, fold and multiply
`default_nettype none

module vtid_hash #(
   parameter int KEY_WIDTH = 16,
   parameter int HASH_BITS = 10
) (
   input  wire logic [KEY_WIDTH-1:0] position_key,
   input  wire logic [KEY_WIDTH-1:0] normal_key,
   input  wire logic [KEY_WIDTH-1:0] texcoord_key,
   output logic      [HASH_BITS-1:0] bucket
);

   localparam int MW = vtid_pkg::MIX_WIDTH;
   localparam int RN = vtid_pkg::ROT_NORMAL;
   localparam int RT = vtid_pkg::ROT_TEXCOORD;

   logic [MW-1:0] pos_w;
   logic [MW-1:0] nrm_w;
   logic [MW-1:0] tex_w;
   logic [MW-1:0] mix;
   logic [MW-1:0] product;

   // Spread the three fields apart so equal indices do not cancel
   always_comb begin
      pos_w   = MW'(position_key);
      nrm_w   = MW'(normal_key);
      tex_w   = MW'(texcoord_key);
      mix     = pos_w ^ ((nrm_w << RN) | (nrm_w >> (MW - RN)))
                      ^ ((tex_w << RT) | (tex_w >> (MW - RT)));
      product = mix * vtid_pkg::HASH_MULT;
   end

   // Take the well-mixed top bits as the bucket
   assign bucket = product[MW-1 -: HASH_BITS];

endmodule

`default_nettype wire

@@ rtl/core/vtid_checker.sv @@
// Port-level checker for the vertex triple index dedup block, with its bind
`default_nettype none

`include "vertex_triple_index_dedup_assert.svh"

module vtid_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_ready,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [9:0] rsp_unified_index,
   input wire logic       rsp_is_new,
   input wire logic       rsp_table_full
);

   // Stalled response must hold its transaction
   `VTID_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_unified_index) && $stable(rsp_is_new) && $stable(rsp_table_full), "response changed while stalled")

   // One corner in flight: an accepted request drops ready for the next cycle
   `VTID_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready, "request taken while a corner is in flight")

   // A corner is either stored or refused, never both
   `VTID_ASSERT_IMPLY(a_flags_exclusive, clock, reset, rsp_valid, !(rsp_is_new && rsp_table_full), "is_new and table_full both set")

   // A refused corner reports index zero
   `VTID_ASSERT_IMPLY(a_full_index_zero, clock, reset, rsp_valid && rsp_table_full, rsp_unified_index == 10'd0, "table_full with non-zero index")

endmodule

bind vertex_triple_index_dedup vtid_checker u_vtid_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_chan.valid),
   .req_ready         (req_chan.ready),
   .rsp_valid         (rsp_chan.valid),
   .rsp_ready         (rsp_chan.ready),
   .rsp_unified_index (rsp_chan.unified_index),
   .rsp_is_new        (rsp_chan.is_new),
   .rsp_table_full    (rsp_chan.table_full)
);

`default_nettype wire
